/* design/ttc_pkg.sv */
package ttc_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_IF       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CARRIER_OFFSET = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIDETONE_HZ    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEMORY_A_FREQ  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEMORY_B_FREQ  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEMORY_A_UPPER = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEMORY_B_UPPER = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPLIT_ENABLE   = 3'd7;

    typedef enum logic [2:0] {
        MODE_KNOB       = 3'd0,
        MODE_START_MIC  = 3'd1,
        MODE_START_CW   = 3'd2,
        MODE_STOP_TX    = 3'd3,
        MODE_OFFSET_ON  = 3'd4,
        MODE_OFFSET_OFF = 3'd5,
        MODE_SET_FREQ   = 3'd6,
        MODE_UNUSED     = 3'd7
    } mode_t;

    localparam logic [31:0] FREQ_21M = 32'd21000000;
    localparam logic [31:0] FREQ_14M = 32'd14000000;
    localparam logic [31:0] FREQ_10M = 32'd10000000;
    localparam logic [31:0] FREQ_7M  = 32'd7000000;

    localparam logic [13:0] STEP_FAST   = 14'd10000;
    localparam logic [13:0] STEP_MEDIUM = 14'd500;
    localparam logic [13:0] STEP_SLOW   = 14'd50;
    localparam logic [13:0] STEP_OFFSET = 14'd100;

    localparam logic [2:0] RELAY_NONE = 3'b000;
    localparam logic [2:0] RELAY_A    = 3'b001;
    localparam logic [2:0] RELAY_B    = 3'b010;
    localparam logic [2:0] RELAY_C    = 3'b100;

    typedef struct packed {
        logic [31:0] first_if;
        logic [23:0] carrier_offset;
        logic [10:0] sidetone_hz;
        logic [25:0] memory_a_freq;
        logic [25:0] memory_b_freq;
        logic        memory_a_upper;
        logic        memory_b_upper;
        logic        split_enable;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        first_if:       32'd45005000,
        carrier_offset: 24'd11052000,
        sidetone_hz:    11'd800,
        memory_a_freq:  26'd7150000,
        memory_b_freq:  26'd14200000,
        memory_a_upper: 1'b0,
        memory_b_upper: 1'b1,
        split_enable:   1'b0
    };

    typedef struct packed {
        logic [31:0] dial;
        logic        usb;
        logic        tx;
        logic        offset_on;
        logic [31:0] offset_tx;
        logic [31:0] offset_rx;
        logic        b_sel;
        logic [31:0] carrier_word;
        logic [31:0] first_lo;
        logic [31:0] second_lo;
        logic [2:0]  relays;
    } state_t;

    localparam state_t STATE_RESET = '{
        dial:         32'd7150000,
        usb:          1'b0,
        tx:           1'b0,
        offset_on:    1'b0,
        offset_tx:    32'd0,
        offset_rx:    32'd0,
        b_sel:        1'b0,
        carrier_word: 32'd11052000,
        first_lo:     32'd52155000,
        second_lo:    32'd33953000,
        relays:       RELAY_B
    };

endpackage

/* design/ttc_cfg_regs.sv */
module ttc_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ttc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ttc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ttc_pkg::cfg_t                   cfg
);
    import ttc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIRST_IF:       cfg_next.first_if       = cfg_data;
                CFG_CARRIER_OFFSET: cfg_next.carrier_offset = cfg_data[23:0];
                CFG_SIDETONE_HZ:    cfg_next.sidetone_hz    = cfg_data[10:0];
                CFG_MEMORY_A_FREQ:  cfg_next.memory_a_freq  = cfg_data[25:0];
                CFG_MEMORY_B_FREQ:  cfg_next.memory_b_freq  = cfg_data[25:0];
                CFG_MEMORY_A_UPPER: cfg_next.memory_a_upper = cfg_data[0];
                CFG_MEMORY_B_UPPER: cfg_next.memory_b_upper = cfg_data[0];
                CFG_SPLIT_ENABLE:   cfg_next.split_enable   = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/ttc_step.sv */
module ttc_step (
    input  ttc_pkg::cfg_t       cfg,
    input  ttc_pkg::state_t     cur,
    input  logic [2:0]          mode,
    input  logic signed [6:0]   knob_count,
    input  logic [31:0]         frequency_word,
    output ttc_pkg::state_t     nxt
);
    import ttc_pkg::*;

    logic [13:0] step_mag;
    logic [31:0] knob_freq;
    logic        knob_usb;
    logic        swap_usb;
    logic [31:0] swap_dial;
    logic        do_tune;
    logic        cw_start;
    logic [31:0] tune_freq;
    logic        tune_usb;
    logic [31:0] tone_32;

    // step size from spin speed, fixed 100 Hz in offset tuning
    always_comb
    begin
        priority if (cur.offset_on)      step_mag = STEP_OFFSET;
        else if (knob_count > 7'sd4)     step_mag = STEP_FAST;
        else if (knob_count > 7'sd2)     step_mag = STEP_MEDIUM;
        else if (knob_count > -7'sd2)    step_mag = STEP_SLOW;
        else if (knob_count > -7'sd4)    step_mag = STEP_MEDIUM;
        else                             step_mag = STEP_FAST;
    end

    assign knob_freq = knob_count[6] ? cur.dial - {18'd0, step_mag}
                                     : cur.dial + {18'd0, step_mag};

    // sideband follows a crossing of 10 MHz, not in offset tuning
    always_comb
    begin
        knob_usb = cur.usb;
        if (!cur.offset_on)
        begin
            if (cur.dial < FREQ_10M && knob_freq > FREQ_10M)
            begin
                knob_usb = 1'b1;
            end
            if (cur.dial > FREQ_10M && knob_freq < FREQ_10M)
            begin
                knob_usb = 1'b0;
            end
        end
    end

    assign swap_usb  = cur.b_sel ? cfg.memory_a_upper : cfg.memory_b_upper;
    assign swap_dial = cur.b_sel ? {6'd0, cfg.memory_a_freq} : {6'd0, cfg.memory_b_freq};
    assign tone_32   = {21'd0, cfg.sidetone_hz};

    always_comb
    begin
        nxt       = cur;
        do_tune   = 1'b0;
        cw_start  = 1'b0;
        tune_freq = cur.dial;
        tune_usb  = cur.usb;
        unique case (mode_t'(mode))
            MODE_KNOB:
            begin
                if (!cur.tx && knob_count != 7'sd0)
                begin
                    do_tune   = 1'b1;
                    tune_freq = knob_freq;
                    tune_usb  = knob_usb;
                end
            end
            MODE_START_MIC, MODE_START_CW:
            begin
                nxt.tx   = 1'b1;
                do_tune  = 1'b1;
                cw_start = (mode_t'(mode) == MODE_START_CW);
                if (cur.offset_on)
                begin
                    nxt.offset_rx = cur.dial;
                    tune_freq     = cur.offset_tx;
                end
                else if (cfg.split_enable)
                begin
                    nxt.b_sel = !cur.b_sel;
                    tune_usb  = swap_usb;
                    tune_freq = swap_dial;
                end
            end
            MODE_STOP_TX:
            begin
                nxt.tx           = 1'b0;
                nxt.carrier_word = {8'd0, cfg.carrier_offset};
                do_tune          = 1'b1;
                if (cur.offset_on)
                begin
                    tune_freq = cur.offset_rx;
                end
                else if (cfg.split_enable)
                begin
                    nxt.b_sel = !cur.b_sel;
                    tune_usb  = swap_usb;
                    tune_freq = swap_dial;
                end
            end
            MODE_OFFSET_ON:
            begin
                nxt.offset_on = 1'b1;
                nxt.offset_tx = frequency_word;
            end
            MODE_OFFSET_OFF:
            begin
                if (cur.offset_on)
                begin
                    nxt.offset_on = 1'b0;
                    do_tune       = 1'b1;
                    tune_freq     = cur.offset_tx;
                end
            end
            MODE_SET_FREQ:
            begin
                do_tune   = 1'b1;
                tune_freq = frequency_word;
            end
            MODE_UNUSED:
            begin
                do_tune = 1'b0;
            end
        endcase

        nxt.usb = tune_usb;
        if (do_tune)
        begin
            priority if (tune_freq > FREQ_21M) nxt.relays = RELAY_NONE;
            else if (tune_freq >= FREQ_14M)    nxt.relays = RELAY_A;
            else if (tune_freq > FREQ_7M)      nxt.relays = RELAY_B;
            else                               nxt.relays = RELAY_C;
            nxt.dial      = tune_freq;
            nxt.first_lo  = cfg.first_if + tune_freq;
            nxt.second_lo = tune_usb ? cfg.first_if + {8'd0, cfg.carrier_offset}
                                     : cfg.first_if - {8'd0, cfg.carrier_offset};
        end
        // morse keys the first oscillator at dial plus or minus the sidetone
        if (cw_start)
        begin
            nxt.carrier_word = 32'd0;
            nxt.second_lo    = 32'd0;
            nxt.first_lo     = tune_usb ? tune_freq + tone_32 : tune_freq - tone_32;
        end
    end

endmodule

/* design/transceiver_tuning_control_core.sv */
// a request is held in the input register, then its result enters the state register
// throughput: one request per cycle while results are taken, set by the single
// next-state pass from the input register into the state register, which also serves as result register
// reset: asynchronous, active low; configuration returns to its defaults, dial to
// 7150000 Hz on lower sideband, receive, offset tuning off, memory A active
module transceiver_tuning_control_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ttc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ttc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [2:0]                      mode,
    input  logic signed [6:0]               knob_count,
    input  logic [31:0]                     frequency_word,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [31:0]                     first_lo_freq,
    output logic [31:0]                     second_lo_freq,
    output logic [31:0]                     carrier_freq,
    output logic [2:0]                      filter_relays,
    output logic                            tx_on,
    output logic [31:0]                     dial_freq,
    output logic                            upper_sideband,
    output logic                            offset_active,
    output logic                            memory_b_active
);
    import ttc_pkg::*;

    cfg_t               cfg;
    state_t             state_reg;
    state_t             state_next;
    logic               in_valid_reg;
    logic [2:0]         mode_reg;
    logic signed [6:0]  knob_count_reg;
    logic [31:0]        frequency_word_reg;
    logic               out_valid_reg;
    logic               advance;

    ttc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ttc_step u_step (
        .cfg            (cfg),
        .cur            (state_reg),
        .mode           (mode_reg),
        .knob_count     (knob_count_reg),
        .frequency_word (frequency_word_reg),
        .nxt            (state_next)
    );

    // a request moves on once the result slot is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg           <= mode;
            knob_count_reg     <= knob_count;
            frequency_word_reg <= frequency_word;
        end
    end

    assign out_valid       = out_valid_reg;
    assign first_lo_freq   = state_reg.first_lo;
    assign second_lo_freq  = state_reg.second_lo;
    assign carrier_freq    = state_reg.carrier_word;
    assign filter_relays   = state_reg.relays;
    assign tx_on           = state_reg.tx;
    assign dial_freq       = state_reg.dial;
    assign upper_sideband  = state_reg.usb;
    assign offset_active   = state_reg.offset_on;
    assign memory_b_active = state_reg.b_sel;

endmodule

/* design/ttc_checker.sv */
module ttc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  filter_relays,
    input logic        tx_on,
    input logic [31:0] dial_freq
);
    import ttc_pkg::*;

    // at most one low-pass relay is ever closed
    a_relays_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(filter_relays))
        else $error("more than one filter relay closed");

    // relay pattern tracks the dial: open above 21 MHz
    a_relays_high_band: assert property (@(posedge clk) disable iff (!rst_n)
        dial_freq > FREQ_21M |-> filter_relays == RELAY_NONE)
        else $error("relays closed above 21 MHz");

    // state only moves together with a new result
    a_state_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!$stable(dial_freq) || !$stable(tx_on)) |-> out_valid)
        else $error("state changed without a result");

    // a stalled result keeps its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dial_freq) && $stable(tx_on))
        else $error("stalled result changed");

endmodule

bind transceiver_tuning_control_core ttc_checker u_ttc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .filter_relays (filter_relays),
    .tx_on         (tx_on),
    .dial_freq     (dial_freq)
);

/* tb/tb.sv */
`timescale 1ns / 100ps

import ttc_pkg::*;

typedef struct packed {
    logic [31:0] first_lo;
    logic [31:0] second_lo;
    logic [31:0] carrier;
    logic [2:0]  relays;
    logic        tx;
    logic [31:0] dial;
    logic        usb;
    logic        offset_on;
    logic        b_sel;
} tuning_report_t;

class tuning_scoreboard;
    cfg_t           cfg;
    state_t         st;
    tuning_report_t tuning_reports[$];
    int             errors;

    function new();
        cfg    = CFG_RESET;
        st     = STATE_RESET;
        errors = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_FIRST_IF:       cfg.first_if       = data;
            CFG_CARRIER_OFFSET: cfg.carrier_offset = data[23:0];
            CFG_SIDETONE_HZ:    cfg.sidetone_hz    = data[10:0];
            CFG_MEMORY_A_FREQ:  cfg.memory_a_freq  = data[25:0];
            CFG_MEMORY_B_FREQ:  cfg.memory_b_freq  = data[25:0];
            CFG_MEMORY_A_UPPER: cfg.memory_a_upper = data[0];
            CFG_MEMORY_B_UPPER: cfg.memory_b_upper = data[0];
            CFG_SPLIT_ENABLE:   cfg.split_enable   = data[0];
            default: ;
        endcase
    endfunction

    function void retune(logic [31:0] f);
        if (f > FREQ_21M)
            st.relays = RELAY_NONE;
        else if (f >= FREQ_14M)
            st.relays = RELAY_A;
        else if (f > FREQ_7M)
            st.relays = RELAY_B;
        else
            st.relays = RELAY_C;
        st.first_lo  = cfg.first_if + f;
        st.second_lo = st.usb ? cfg.first_if + 32'(cfg.carrier_offset)
                              : cfg.first_if - 32'(cfg.carrier_offset);
        st.dial      = f;
    endfunction

    function void toggle_memory();
        if (st.b_sel)
        begin
            st.b_sel = 1'b0;
            st.usb   = cfg.memory_a_upper;
            st.dial  = 32'(cfg.memory_a_freq);
        end
        else
        begin
            st.b_sel = 1'b1;
            st.usb   = cfg.memory_b_upper;
            st.dial  = 32'(cfg.memory_b_freq);
        end
    endfunction

    function void begin_transmit(bit morse);
        st.tx = 1'b1;
        if (st.offset_on)
        begin
            st.offset_rx = st.dial;
            retune(st.offset_tx);
        end
        else
        begin
            if (cfg.split_enable)
                toggle_memory();
            retune(st.dial);
        end
        // morse keys the first oscillator directly at dial plus or minus sidetone
        if (morse)
        begin
            st.carrier_word = '0;
            st.second_lo    = '0;
            st.first_lo     = st.usb ? st.dial + 32'(cfg.sidetone_hz)
                                     : st.dial - 32'(cfg.sidetone_hz);
        end
    endfunction

    function void end_transmit();
        st.tx           = 1'b0;
        st.carrier_word = 32'(cfg.carrier_offset);
        if (st.offset_on)
            retune(st.offset_rx);
        else
        begin
            if (cfg.split_enable)
                toggle_memory();
            retune(st.dial);
        end
    endfunction

    function void turn_knob(int s);
        logic [31:0] prev;
        logic [31:0] f;
        prev = st.dial;
        f    = st.dial;
        if (st.tx || s == 0)
            return;
        if (st.offset_on)
        begin
            f = (s < 0) ? f - 32'(STEP_OFFSET) : f + 32'(STEP_OFFSET);
            retune(f);
            return;
        end
        if (s > 4)
            f = f + 32'(STEP_FAST);
        else if (s > 2)
            f = f + 32'(STEP_MEDIUM);
        else if (s > 0)
            f = f + 32'(STEP_SLOW);
        else if (s > -2)
            f = f - 32'(STEP_SLOW);
        else if (s > -4)
            f = f - 32'(STEP_MEDIUM);
        else
            f = f - 32'(STEP_FAST);
        // sideband flips only on a strict crossing of 10 MHz
        if (prev < FREQ_10M && f > FREQ_10M)
            st.usb = 1'b1;
        if (prev > FREQ_10M && f < FREQ_10M)
            st.usb = 1'b0;
        retune(f);
    endfunction

    function void note_request(logic [2:0] m, logic signed [6:0] k, logic [31:0] fw);
        case (m)
            MODE_KNOB:      turn_knob(int'(k));
            MODE_START_MIC: begin_transmit(1'b0);
            MODE_START_CW:  begin_transmit(1'b1);
            MODE_STOP_TX:   end_transmit();
            MODE_OFFSET_ON:
            begin
                st.offset_on = 1'b1;
                st.offset_tx = fw;
            end
            MODE_OFFSET_OFF:
            begin
                if (st.offset_on)
                begin
                    st.offset_on = 1'b0;
                    retune(st.offset_tx);
                end
            end
            MODE_SET_FREQ:  retune(fw);
            default: ;
        endcase
        tuning_reports.push_back('{st.first_lo, st.second_lo, st.carrier_word, st.relays,
                                   st.tx, st.dial, st.usb, st.offset_on, st.b_sel});
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(tuning_report_t got);
        tuning_report_t want;
        if (tuning_reports.size() == 0)
        begin
            $error("result with no request outstanding");
            errors++;
            return;
        end
        want = tuning_reports.pop_front();
        compare_field("first_lo_freq",   want.first_lo,       got.first_lo);
        compare_field("second_lo_freq",  want.second_lo,      got.second_lo);
        compare_field("carrier_freq",    want.carrier,        got.carrier);
        compare_field("filter_relays",   32'(want.relays),    32'(got.relays));
        compare_field("tx_on",           32'(want.tx),        32'(got.tx));
        compare_field("dial_freq",       want.dial,           got.dial);
        compare_field("upper_sideband",  32'(want.usb),       32'(got.usb));
        compare_field("offset_active",   32'(want.offset_on), 32'(got.offset_on));
        compare_field("memory_b_active", 32'(want.b_sel),     32'(got.b_sel));
    endfunction

    function int pending();
        return tuning_reports.size();
    endfunction
endclass

module tb;
    logic                    clk            = 1'b0;
    logic                    rst_n          = 1'b0;
    logic                    cfg_we         = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0]   cfg_data       = '0;
    logic                    in_valid       = 1'b0;
    logic                    in_ready;
    logic [2:0]              mode           = '0;
    logic signed [6:0]       knob_count     = '0;
    logic [31:0]             frequency_word = '0;
    logic                    out_valid;
    logic                    out_ready      = 1'b0;
    logic [31:0]             first_lo_freq;
    logic [31:0]             second_lo_freq;
    logic [31:0]             carrier_freq;
    logic [2:0]              filter_relays;
    logic                    tx_on;
    logic [31:0]             dial_freq;
    logic                    upper_sideband;
    logic                    offset_active;
    logic                    memory_b_active;

    tuning_scoreboard sb;
    int send_idle  = 0;
    int recv_stall = 0;
    int sent       = 0;

    transceiver_tuning_control_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .knob_count      (knob_count),
        .frequency_word  (frequency_word),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .first_lo_freq   (first_lo_freq),
        .second_lo_freq  (second_lo_freq),
        .carrier_freq    (carrier_freq),
        .filter_relays   (filter_relays),
        .tx_on           (tx_on),
        .dial_freq       (dial_freq),
        .upper_sideband  (upper_sideband),
        .offset_active   (offset_active),
        .memory_b_active (memory_b_active)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall);
    end

    // check results before noting requests: a result never belongs to a request of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(tuning_report_t'{first_lo_freq, second_lo_freq, carrier_freq,
                                                 filter_relays, tx_on, dial_freq,
                                                 upper_sideband, offset_active,
                                                 memory_b_active});
            if (in_valid && in_ready)
                sb.note_request(mode, knob_count, frequency_word);
        end
    end

    // called and returns at a falling edge
    task automatic send_request(input logic [2:0] m, input logic signed [6:0] k,
                                input logic [31:0] fw);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        mode           <= m;
        knob_count     <= k;
        frequency_word <= fw;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (sb.pending() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        if (sb.pending() != 0)
        begin
            $error("%0d results never arrived", sb.pending());
            sb.errors++;
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic configure_phase(input int p);
        if (p == 1)
        begin
            write_reg(CFG_FIRST_IF,       32'd0);
            write_reg(CFG_CARRIER_OFFSET, 32'd11048000);
            write_reg(CFG_SIDETONE_HZ,    32'd100);
            write_reg(CFG_MEMORY_A_FREQ,  32'd3500000);
            write_reg(CFG_MEMORY_B_FREQ,  32'd35000000);
            write_reg(CFG_MEMORY_A_UPPER, 32'd1);
            write_reg(CFG_MEMORY_B_UPPER, 32'd0);
            write_reg(CFG_SPLIT_ENABLE,   32'd1);
        end
        else if (p == 2)
        begin
            write_reg(CFG_FIRST_IF,       32'hFFFF_FFFF);
            write_reg(CFG_CARRIER_OFFSET, 32'd11060000);
            write_reg(CFG_SIDETONE_HZ,    32'd2000);
            write_reg(CFG_MEMORY_A_FREQ,  32'd35000000);
            write_reg(CFG_MEMORY_B_FREQ,  32'd3500000);
            write_reg(CFG_MEMORY_A_UPPER, 32'd0);
            write_reg(CFG_MEMORY_B_UPPER, 32'd1);
            write_reg(CFG_SPLIT_ENABLE,   32'd1);
        end
        else
        begin
            write_reg(CFG_FIRST_IF,       $urandom());
            write_reg(CFG_CARRIER_OFFSET, $urandom_range(11060000, 11048000));
            write_reg(CFG_SIDETONE_HZ,    $urandom_range(2000, 100));
            write_reg(CFG_MEMORY_A_FREQ,  $urandom_range(35000000, 3500000));
            write_reg(CFG_MEMORY_B_FREQ,  $urandom_range(35000000, 3500000));
            write_reg(CFG_MEMORY_A_UPPER, $urandom_range(1));
            write_reg(CFG_MEMORY_B_UPPER, $urandom_range(1));
            write_reg(CFG_SPLIT_ENABLE,   $urandom_range(1));
        end
    endtask

    // mostly around the relay and sideband boundaries, some anywhere, some near wrap
    function automatic logic [31:0] pick_freq();
        logic [31:0] bounds [4] = '{FREQ_7M, FREQ_10M, FREQ_14M, FREQ_21M};
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return bounds[$urandom_range(3)] + $urandom_range(40000) - 20000;
            5, 6, 7:       return $urandom_range(35000000, 3500000);
            8:             return $urandom();
            default:       return $urandom_range(20000) - 10000;
        endcase
    endfunction

    task automatic random_request();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            send_request(MODE_KNOB, ($urandom_range(9) == 0) ? 7'sd0 : 7'($urandom_range(127)),
                         $urandom());
        else if (r < 55)
            send_request(MODE_SET_FREQ, 7'($urandom_range(127)), pick_freq());
        else if (r < 61)
            send_request(MODE_START_MIC, 7'($urandom_range(127)), $urandom());
        else if (r < 66)
            send_request(MODE_START_CW, 7'($urandom_range(127)), $urandom());
        else if (r < 78)
            send_request(MODE_STOP_TX, 7'($urandom_range(127)), $urandom());
        else if (r < 85)
            send_request(MODE_OFFSET_ON, 7'($urandom_range(127)), pick_freq());
        else if (r < 96)
            send_request(MODE_OFFSET_OFF, 7'($urandom_range(127)), $urandom());
        else
            send_request(MODE_UNUSED, 7'($urandom_range(127)), $urandom());
    endtask

    // park at a picked frequency, mostly near a boundary, then spin one way so the dial walks across it
    task automatic knob_sweep();
        int n;
        int k;
        bit down;
        n    = $urandom_range(8, 3);
        down = $urandom_range(1);
        send_request(MODE_SET_FREQ, '0, pick_freq());
        repeat (n)
        begin
            k = $urandom_range(63, 1);
            send_request(MODE_KNOB, down ? 7'(-k) : 7'(k), $urandom());
        end
    endtask

    task automatic directed_requests();
        send_request(MODE_UNUSED, '0, '0);
        send_request(MODE_KNOB, 7'sd0, '0);
        send_request(MODE_KNOB, 7'sd1, '0);
        send_request(MODE_KNOB, 7'sd3, '0);
        send_request(MODE_KNOB, 7'sd63, '0);
        send_request(MODE_KNOB, -7'sd1, '0);
        send_request(MODE_KNOB, -7'sd3, '0);
        send_request(MODE_KNOB, -7'sd64, '0);
        // cross 10 MHz upward then back down
        send_request(MODE_SET_FREQ, '0, 32'd9999990);
        send_request(MODE_KNOB, 7'sd5, '0);
        send_request(MODE_KNOB, -7'sd64, '0);
        send_request(MODE_SET_FREQ, '0, 32'd21000001);
        send_request(MODE_SET_FREQ, '0, FREQ_21M);
        send_request(MODE_SET_FREQ, '0, FREQ_14M);
        send_request(MODE_SET_FREQ, '0, 32'd13999999);
        send_request(MODE_SET_FREQ, '0, 32'd7000001);
        send_request(MODE_SET_FREQ, '0, FREQ_7M);
        send_request(MODE_SET_FREQ, '0, 32'd0);
        send_request(MODE_SET_FREQ, 7'sd63, 32'hFFFF_FFFF);
        send_request(MODE_KNOB, 7'sd2, '0);
        send_request(MODE_SET_FREQ, '0, 32'd7100000);
        // knob ignored while transmitting, repeated start and stop
        send_request(MODE_START_MIC, '0, '0);
        send_request(MODE_KNOB, 7'sd5, '0);
        send_request(MODE_START_MIC, '0, '0);
        send_request(MODE_STOP_TX, '0, '0);
        send_request(MODE_STOP_TX, '0, '0);
        send_request(MODE_START_CW, '0, '0);
        send_request(MODE_STOP_TX, '0, '0);
        send_request(MODE_OFFSET_OFF, '0, '0);
        send_request(MODE_OFFSET_ON, '0, 32'd14074000);
        send_request(MODE_KNOB, 7'sd1, '0);
        send_request(MODE_KNOB, -7'sd1, '0);
        send_request(MODE_START_CW, '0, '0);
        send_request(MODE_STOP_TX, '0, '0);
        send_request(MODE_OFFSET_OFF, '0, '0);
    endtask

    initial
    begin
        int target;
        sb = new();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int p = 0; p < 8; p++)
        begin
            if (p > 0)
            begin
                drain_results();
                configure_phase(p);
            end
            case (p % 4)
                0:       begin send_idle = 0;  recv_stall = 0;  end
                1:       begin send_idle = 80; recv_stall = 0;  end
                2:       begin send_idle = 0;  recv_stall = 80; end
                default: begin send_idle = 18; recv_stall = 18; end
            endcase
            if (p == 0)
                directed_requests();
            target = sent + 200;
            while (sent < target)
            begin
                if ($urandom_range(99) < 12)
                    knob_sweep();
                else
                    random_request();
            end
        end
        drain_results();
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
